>>> rtl/core/dht_pkg.sv
// shared types and constants for the double hashing table core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dht_pkg;

	localparam int KEY_W        = 31;
	localparam int SLOT_W       = 4;
	localparam int STATUS_W     = 3;
	localparam int IN_TDATA_W   = 32;
	localparam int OUT_TDATA_W  = 8;

	localparam int QUEUE_DEPTH  = 2;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_SEARCH  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_KEY   = 3'd4
	} status_t;

	typedef struct packed {
		logic             operation;
		logic             bad_key;
		logic [KEY_W-1:0] key;
	} req_head_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_index;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/dht_front.sv
// front end: takes requests and works out home slot and probe step
// depends on dht_pkg
`timescale 1ns / 1ps
`default_nettype none

module dht_front
	import dht_pkg::*;
#(
	parameter int TABLE_SIZE = 10,
	parameter int STEP_PRIME = 7
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           hold,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [IN_TDATA_W-1:0]         s_tdata,   // key[30:0], zero
	input  wire  [0:0]                    s_tuser,   // operation
	output logic                          req_valid,
	input  wire                           req_ready,
	output req_head_t                     req_head,
	output logic [$clog2(TABLE_SIZE)-1:0] req_home,
	output logic [$clog2(TABLE_SIZE)-1:0] req_step
);

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int PRM_W  = $clog2(STEP_PRIME);
	localparam int STEP_W = $clog2(STEP_PRIME + 1);
	localparam int MAG_W  = KEY_W + 1;
	localparam int PROD_W = KEY_W + MAG_W;
	localparam int SH_T   = KEY_W + IDX_W;
	localparam int SH_P   = KEY_W + PRM_W;

	// rounded-up reciprocals, the quotient is exact for any key below 2^KEY_W
	localparam logic [MAG_W-1:0] MAG_T =
		MAG_W'(((64'd1 << SH_T) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
	localparam logic [MAG_W-1:0] MAG_P =
		MAG_W'(((64'd1 << SH_P) + 64'(STEP_PRIME) - 64'd1) / 64'(STEP_PRIME));
	localparam logic [IDX_W-1:0]  TS_LO = IDX_W'(TABLE_SIZE);
	localparam logic [PRM_W-1:0]  SP_LO = PRM_W'(STEP_PRIME);
	localparam logic [STEP_W-1:0] SP_W  = STEP_W'(STEP_PRIME);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MUL  = 3'd1;
	localparam logic [2:0] F_REM  = 3'd2;
	localparam logic [2:0] F_SMUL = 3'd3;
	localparam logic [2:0] F_SREM = 3'd4;
	localparam logic [2:0] F_PUSH = 3'd5;

	logic [2:0]        state_q;
	req_head_t         head_q;
	logic [IDX_W-1:0]  qt_q, rh_q, rs_q;
	logic [PRM_W-1:0]  qp_q;
	logic [STEP_W-1:0] step_q;
	logic              accept, on_step;
	logic [KEY_W-1:0]  src;
	logic [PROD_W-1:0] prod_t, prod_p;
	logic [IDX_W-1:0]  rem_t;
	logic [PRM_W-1:0]  rem_p;

	assign s_tready = (state_q == F_IDLE) && !hold;
	assign accept   = s_tvalid && s_tready;

	// one table-size multiplier serves the key and then the step
	assign on_step = (state_q == F_SMUL) || (state_q == F_SREM);
	assign src     = on_step ? KEY_W'(step_q) : head_q.key;
	assign prod_t  = PROD_W'(src) * PROD_W'(MAG_T);
	assign prod_p  = PROD_W'(head_q.key) * PROD_W'(MAG_P);

	// remainder fits the low bits, so only those of the quotient are kept
	assign rem_t = src[IDX_W-1:0] - qt_q * TS_LO;
	assign rem_p = head_q.key[PRM_W-1:0] - qp_q * SP_LO;

	assign req_valid = (state_q == F_PUSH);
	assign req_head  = head_q;
	assign req_home  = rh_q;
	assign req_step  = rs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) state_q <= F_MUL;
				end
				F_MUL:  state_q <= F_REM;
				F_REM:  state_q <= F_SMUL;
				F_SMUL: state_q <= F_SREM;
				F_SREM: state_q <= F_PUSH;
				F_PUSH: begin
					if (req_ready) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_q.operation <= s_tuser[0];
			head_q.key       <= s_tdata[KEY_W-1:0];
			head_q.bad_key   <= (s_tdata[KEY_W-1:0] == '0);
		end
		if (state_q == F_MUL || state_q == F_SMUL) qt_q <= prod_t[SH_T +: IDX_W];
		if (state_q == F_MUL) qp_q <= prod_p[SH_P +: PRM_W];
		if (state_q == F_REM) begin
			rh_q   <= rem_t;
			// step is the prime minus key mod prime, never zero
			step_q <= SP_W - STEP_W'(rem_p);
		end
		// step folded into the table range
		if (state_q == F_SREM) rs_q <= rem_t;
	end

endmodule

`default_nettype wire

>>> rtl/core/dht_queue.sv
// two-entry request queue between front and back
// depends on dht_pkg
`timescale 1ns / 1ps
`default_nettype none

module dht_queue
	import dht_pkg::*;
#(
	parameter int W = 8
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          wr_valid,
	output logic         wr_ready,
	input  wire  [W-1:0] wr_data,
	output logic         rd_valid,
	input  wire          rd_ready,
	output logic [W-1:0] rd_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign wr_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = entry_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wp_q] <= wr_data;
	end

endmodule

`default_nettype wire

>>> rtl/core/dht_back.sv
// back end: slot memory, clearing pass and the probe sequencer
// depends on dht_pkg
`timescale 1ns / 1ps
`default_nettype none

module dht_back
	import dht_pkg::*;
#(
	parameter int TABLE_SIZE = 10
) (
	input  wire                           clk,
	input  wire                           arst_n,
	output logic                          clearing,
	input  wire                           req_valid,
	output logic                          req_ready,
	input  req_head_t                     req_head,
	input  wire  [$clog2(TABLE_SIZE)-1:0] req_home,
	input  wire  [$clog2(TABLE_SIZE)-1:0] req_step,
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [OUT_TDATA_W-1:0]        m_tdata    // slot_index[3:0], status[6:4], zero
);

	localparam int IDX_W = $clog2(TABLE_SIZE);

	localparam logic [1:0] B_CLEAR = 2'd0;
	localparam logic [1:0] B_IDLE  = 2'd1;
	localparam logic [1:0] B_PROBE = 2'd2;

	logic [KEY_W-1:0] slot_mem_q [TABLE_SIZE];
	logic [KEY_W-1:0] rd_data_q;

	logic [1:0]       state_q, state_n;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] cur_q, step_q, cnt_q;
	logic [KEY_W-1:0] key_q;
	logic             op_q;
	logic             m_tvalid_q;
	result_t          res_q, res_d;

	logic             out_free;
	logic             rd_en, wr_en, res_load, load_item, advance;
	logic [IDX_W-1:0] rd_addr, wr_addr, next_addr;
	logic [KEY_W-1:0] wr_data;
	logic [IDX_W:0]   sum;
	logic             is_empty, is_match, is_last;

	assign clearing = (state_q == B_CLEAR);
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, res_q};

	assign is_empty = (rd_data_q == '0);
	assign is_match = (rd_data_q == key_q);
	assign is_last  = (cnt_q == IDX_W'(TABLE_SIZE - 1));

	// both terms stay below the table size, so one subtract folds the sum
	assign sum       = {1'b0, cur_q} + {1'b0, step_q};
	assign next_addr = (sum >= (IDX_W + 1)'(TABLE_SIZE)) ?
	                   IDX_W'(sum - (IDX_W + 1)'(TABLE_SIZE)) : sum[IDX_W-1:0];

	always_comb begin
		state_n   = state_q;
		req_ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = req_home;
		wr_en     = 1'b0;
		wr_addr   = cur_q;
		wr_data   = key_q;
		res_load  = 1'b0;
		res_d     = '{status: ST_BAD_KEY, slot_index: '0};
		load_item = 1'b0;
		advance   = 1'b0;
		unique case (state_q)
			B_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == IDX_W'(TABLE_SIZE - 1)) state_n = B_IDLE;
			end
			B_IDLE: begin
				if (req_valid) begin
					if (req_head.bad_key) begin
						// zero key never touches the table
						if (out_free) begin
							req_ready = 1'b1;
							res_load  = 1'b1;
						end
					end else begin
						req_ready = 1'b1;
						load_item = 1'b1;
						rd_en     = 1'b1;
						rd_addr   = req_home;
						state_n   = B_PROBE;
					end
				end
			end
			B_PROBE: begin
				rd_addr = next_addr;
				if (op_q == OP_INSERT) begin
					priority if (is_empty) begin
						res_d = '{status: ST_INSERTED, slot_index: SLOT_W'(cur_q)};
						res_load = out_free;
						wr_en    = out_free;
					end else if (is_last) begin
						res_d = '{status: ST_FULL, slot_index: '0};
						res_load = out_free;
					end else begin
						advance = 1'b1;
					end
				end else begin
					priority if (is_match) begin
						res_d = '{status: ST_FOUND, slot_index: SLOT_W'(cur_q)};
						res_load = out_free;
					end else if (is_empty || is_last) begin
						res_d = '{status: ST_NOT_FOUND, slot_index: '0};
						res_load = out_free;
					end else begin
						advance = 1'b1;
					end
				end
				if (advance) rd_en = 1'b1;
				if (res_load) state_n = B_IDLE;
			end
			default: state_n = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_CLEAR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == B_CLEAR) clr_q <= clr_q + 1'b1;
			if (res_load)      m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res_d;
		if (load_item) begin
			key_q  <= req_head.key;
			op_q   <= req_head.operation;
			step_q <= req_step;
			cur_q  <= req_home;
			cnt_q  <= '0;
		end else if (advance) begin
			cur_q <= next_addr;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slot_mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= slot_mem_q[rd_addr];
	end

endmodule

`default_nettype wire

>>> rtl/core/double_hash_table_core.sv
// channel     dir   handshake            contents
// s_*         in    s_tvalid / s_tready  tdata key, tuser operation
// m_*         out   m_tvalid / m_tready  tdata slot_index and status
//
// front: takes a request, works out home slot and step by reciprocal multiply
// (F_MUL, F_REM), folds the step into the table range (F_SMUL, F_SREM), then
// hands it on (F_PUSH). back: issues the home read, then probes one slot at a time,
// 1 to TABLE_SIZE probes, set by the single read port of the slot memory.
// after reset a clearing pass empties the slots; no request is taken until it ends.
// the queue and the output register let either side stall.
//
// top level of the double hashing table core, depends on dht_pkg, dht_front,
// dht_queue and dht_back
`timescale 1ns / 1ps
`default_nettype none

module double_hash_table_core
	import dht_pkg::*;
#(
	parameter int TABLE_SIZE = 10,
	parameter int STEP_PRIME = 7
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  wire  [IN_TDATA_W-1:0]  s_tdata,   // key[30:0], zero
	input  wire  [0:0]             s_tuser,   // operation
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // slot_index[3:0], status[6:4], zero
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int Q_W   = $bits(req_head_t) + 2 * IDX_W;

	logic             clearing;
	logic             f_valid, f_ready, b_valid, b_ready;
	req_head_t        f_head, b_head;
	logic [IDX_W-1:0] f_home, f_step, b_home, b_step;
	logic [Q_W-1:0]   q_in, q_out;

	dht_front #(
		.TABLE_SIZE (TABLE_SIZE),
		.STEP_PRIME (STEP_PRIME)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold      (clearing),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.req_valid (f_valid),
		.req_ready (f_ready),
		.req_head  (f_head),
		.req_home  (f_home),
		.req_step  (f_step)
	);

	assign q_in = {f_head, f_home, f_step};
	assign {b_head, b_home, b_step} = q_out;

	dht_queue #(
		.W (Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (q_in),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (q_out)
	);

	dht_back #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.req_valid (b_valid),
		.req_ready (b_ready),
		.req_head  (b_head),
		.req_home  (b_home),
		.req_step  (b_step),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

>>> rtl/core/dht_checker.sv
// port-level checks for the double hashing table core, bound to the top level
// depends on dht_pkg
`timescale 1ns / 1ps
`default_nettype none

module dht_checker
	import dht_pkg::*;
#(
	parameter int TABLE_SIZE = 10
) (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   s_tvalid,
	input wire                   s_tready,
	input wire                   m_tvalid,
	input wire                   m_tready,
	input wire [OUT_TDATA_W-1:0] m_tdata
);

	logic [3:0] pend_q;
	logic       in_acc, out_acc;
	logic [2:0] st;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign st      = m_tdata[6:4];

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else         pend_q <= pend_q + 4'(in_acc) - 4'(out_acc);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 4'd0)
		else $error("result without a pending request");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == ST_NOT_FOUND || st == ST_FULL || st == ST_BAD_KEY)
		|-> m_tdata[3:0] == 4'd0)
		else $error("slot index set on a miss");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == ST_INSERTED || st == ST_FOUND) |-> m_tdata[3:0] < TABLE_SIZE)
		else $error("slot index outside the table");

endmodule

bind double_hash_table_core dht_checker #(.TABLE_SIZE(TABLE_SIZE)) u_dht_checker (.*);

`default_nettype wire
